// File: hw/rtl/pose_tracker_gain_update_assert.svh
// assertion helpers for the pose tracker
`ifndef POSE_TRACKER_GAIN_UPDATE_ASSERT_SVH
`define POSE_TRACKER_GAIN_UPDATE_ASSERT_SVH

// same-cycle implication
`define PTGU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PTGU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/ptgu_pkg.sv
`timescale 1ns / 1ps
package ptgu_pkg;

    localparam logic [31:0] VAR_RESET = 32'd42949673;

    // negated hamilton terms, bit index is component * 4 + term
    localparam logic [15:0] HAM_NEG = 16'h428E;

    typedef enum logic [1:0] {
        FUNC_INIT    = 2'd0,
        FUNC_PREDICT = 2'd1,
        FUNC_UPDATE  = 2'd2,
        FUNC_RENORM  = 2'd3
    } t_func;

    typedef struct packed {
        logic issue;
        logic clr;
        logic neg;
    } t_mac_ctl;

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        logic signed [31:0] r;
        if (v > 68'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -68'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/ptgu_mac.sv
`timescale 1ns / 1ps
module ptgu_mac (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ptgu_pkg::t_mac_ctl   i_ctl,
    input  logic signed [32:0]   i_op_a,
    input  logic signed [32:0]   i_op_b,
    output logic signed [67:0]   o_acc
);
    import ptgu_pkg::*;

    t_mac_ctl           r_ctl;
    logic signed [65:0] r_prod;
    logic signed [67:0] r_acc;
    logic signed [67:0] n_acc;

    // product registered, accumulated into r_acc in the following cycle
    always_comb begin
        n_acc = r_ctl.clr ? 68'sd0 : r_acc;
        if (r_ctl.neg) begin
            n_acc = n_acc - 68'(r_prod);
        end else begin
            n_acc = n_acc + 68'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
        r_prod <= i_op_a * i_op_b;
        if (r_ctl.issue) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

// File: hw/rtl/pose_tracker_gain_update.sv
`timescale 1ns / 1ps
// pose tracker with scalar-gain position update
// input channel: i_valid / o_stall carry one command word (func, values,
// quaternion, time step, noise); a word is taken when i_valid is high and
// o_stall is low. output channel: o_valid / i_stall carry the full state
// after the command; taken when o_valid is high and i_stall is low.
// one word at a time: o_stall stays high from acceptance until the result
// has been taken. all work runs on one registered 33x33 multiply-accumulate
// unit and one shared 60-bit compare/subtract unit under a sequencer.
// work per command: initialize stores the word directly; update runs 31
// gain-divide steps plus four multiplies; renormalize runs four squares,
// 30 square root steps and four 15-step divides; predict runs two position
// multiplies and 16 hamilton multiplies, then the renormalize steps.
// while the receiver stalls, the result holds and no new word is taken.
// reset (synchronous, active low) clears position and quaternion and sets
// both variances to 0.01; no result is pending afterwards.
`include "pose_tracker_gain_update_assert.svh"
module pose_tracker_gain_update (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_func,
    input  logic signed [31:0] i_val_a,
    input  logic signed [31:0] i_val_b,
    input  logic signed [15:0] i_quat_w,
    input  logic signed [15:0] i_quat_x,
    input  logic signed [15:0] i_quat_y,
    input  logic signed [15:0] i_quat_z,
    input  logic [19:0]        i_time_step,
    input  logic [31:0]        i_meas_noise,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [15:0] o_ori_w,
    output logic signed [15:0] o_ori_x,
    output logic signed [15:0] o_ori_y,
    output logic signed [15:0] o_ori_z,
    output logic [31:0]        o_var_x,
    output logic [31:0]        o_var_y
);
    import ptgu_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_WAIT, S_PX, S_PY, S_PYD, S_HAM, S_HAMD, S_SQ, S_SQD,
        S_SQRT, S_DLD, S_DIV, S_KDIV, S_KX, S_KY, S_VX, S_VY, S_VD, S_DONE
    } t_state;

    t_state             r_state;
    t_state             r_ret;
    logic [4:0]         r_cnt;
    logic [1:0]         r_k;
    logic               r_out_valid;

    logic signed [31:0] r_a;
    logic signed [31:0] r_b;
    logic signed [15:0] r_dq [4];
    logic [19:0]        r_dt;

    logic signed [31:0] r_est_x;
    logic signed [31:0] r_est_y;
    logic signed [15:0] r_ori [4];
    logic [31:0]        r_var_x;
    logic [31:0]        r_var_y;

    logic signed [19:0] r_c [4];
    logic [29:0]        r_n;
    logic [59:0]        r_rem;
    logic [59:0]        r_opb;
    logic [59:0]        r_root;

    t_mac_ctl           mac_ctl;
    logic signed [32:0] mac_a;
    logic signed [32:0] mac_b;
    logic signed [67:0] mac_acc;

    logic [59:0]        cs_a;
    logic [59:0]        cs_b;
    logic               cs_ge;
    logic [59:0]        cs_diff;
    logic [59:0]        root_nx;

    logic [30:0]        gain;
    logic [30:0]        gain_c;
    logic signed [67:0] acc_q16;
    logic signed [67:0] acc_q30;
    logic signed [67:0] acc_q14;
    logic [3:0]         ham_j;
    logic [1:0]         ham_comp;
    logic [1:0]         ham_term;
    logic [19:0]        c_abs;
    logic [14:0]        quo;
    logic signed [15:0] quo_s;
    logic               in_take;

    assign in_take  = i_valid && !o_stall;
    assign ham_j    = r_cnt[3:0];
    assign ham_comp = ham_j[3:2];
    assign ham_term = ham_j[1:0];
    assign gain     = (r_opb == '0) ? 31'd0 : r_root[30:0];
    assign gain_c   = (31'd1 << 30) - gain;
    assign acc_q16  = (mac_acc + 68'sd32768) >>> 16;
    assign acc_q30  = (mac_acc + 68'sd536870912) >>> 30;
    assign acc_q14  = (mac_acc + 68'sd8192) >>> 14;
    assign c_abs    = r_c[r_k][19] ? 20'(-r_c[r_k]) : 20'(r_c[r_k]);
    assign quo      = {r_root[13:0], cs_ge};
    assign quo_s    = r_c[r_k][19] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

    // shared compare / subtract unit
    always_comb begin
        cs_a = r_rem;
        cs_b = r_opb;
        case (r_state)
            S_SQRT: cs_b = r_root + r_opb;
            S_KDIV: cs_a = {r_rem[58:0], (r_cnt == 5'd0) ? r_var_x[0] : 1'b0};
            default: ;
        endcase
    end

    assign cs_ge   = cs_a >= cs_b;
    assign cs_diff = cs_a - cs_b;
    assign root_nx = cs_ge ? (r_root >> 1) + r_opb : r_root >> 1;

    // multiplier operand selection
    always_comb begin
        mac_ctl = '0;
        mac_a   = '0;
        mac_b   = '0;
        case (r_state)
            S_PX: begin
                mac_ctl = '{issue: 1'b1, clr: 1'b1, neg: 1'b0};
                mac_a   = 33'(r_a);
                mac_b   = $signed({13'd0, r_dt});
            end
            S_PY: begin
                mac_ctl = '{issue: 1'b1, clr: 1'b1, neg: 1'b0};
                mac_a   = 33'(r_b);
                mac_b   = $signed({13'd0, r_dt});
            end
            S_HAM: begin
                mac_ctl = '{issue: 1'b1, clr: (ham_term == 2'd0), neg: HAM_NEG[ham_j]};
                mac_a   = 33'(r_dq[ham_term]);
                mac_b   = 33'(r_ori[ham_comp ^ ham_term]);
            end
            S_SQ: begin
                mac_ctl = '{issue: 1'b1, clr: (r_cnt[1:0] == 2'd0), neg: 1'b0};
                mac_a   = 33'(r_c[r_cnt[1:0]]);
                mac_b   = 33'(r_c[r_cnt[1:0]]);
            end
            S_KX: begin
                mac_ctl = '{issue: 1'b1, clr: 1'b1, neg: 1'b0};
                mac_a   = 33'(r_a) - 33'(r_est_x);
                mac_b   = $signed({2'b0, gain});
            end
            S_KY: begin
                mac_ctl = '{issue: 1'b1, clr: 1'b1, neg: 1'b0};
                mac_a   = 33'(r_b) - 33'(r_est_y);
                mac_b   = $signed({2'b0, gain});
            end
            S_VX: begin
                mac_ctl = '{issue: 1'b1, clr: 1'b1, neg: 1'b0};
                mac_a   = $signed({1'b0, r_var_x});
                mac_b   = $signed({2'b0, gain_c});
            end
            S_VY: begin
                mac_ctl = '{issue: 1'b1, clr: 1'b1, neg: 1'b0};
                mac_a   = $signed({1'b0, r_var_y});
                mac_b   = $signed({2'b0, gain_c});
            end
            default: ;
        endcase
    end

    ptgu_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_op_a  (mac_a),
        .i_op_b  (mac_b),
        .o_acc   (mac_acc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_IDLE;
            r_cnt       <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
            r_est_x     <= '0;
            r_est_y     <= '0;
            r_var_x     <= VAR_RESET;
            r_var_y     <= VAR_RESET;
            for (int i = 0; i < 4; i++) begin
                r_ori[i] <= '0;
            end
        end else begin
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_a   <= i_val_a;
                        r_b   <= i_val_b;
                        r_dq[0] <= i_quat_w;
                        r_dq[1] <= i_quat_x;
                        r_dq[2] <= i_quat_y;
                        r_dq[3] <= i_quat_z;
                        r_dt  <= i_time_step;
                        r_cnt <= '0;
                        unique case (t_func'(i_func))
                            FUNC_INIT: begin
                                r_est_x  <= i_val_a;
                                r_est_y  <= i_val_b;
                                r_ori[0] <= i_quat_w;
                                r_ori[1] <= i_quat_x;
                                r_ori[2] <= i_quat_y;
                                r_ori[3] <= i_quat_z;
                                r_state  <= S_DONE;
                            end
                            FUNC_PREDICT: begin
                                r_state <= S_PX;
                            end
                            FUNC_UPDATE: begin
                                // den = var_x + R * 2^16, quotient bits from 2^30 down
                                r_opb   <= {28'd0, r_var_x} + {12'd0, i_meas_noise, 16'd0};
                                r_rem   <= {29'd0, r_var_x[31:1]};
                                r_root  <= '0;
                                r_state <= S_KDIV;
                            end
                            FUNC_RENORM: begin
                                for (int i = 0; i < 4; i++) begin
                                    r_c[i] <= 20'(r_ori[i]);
                                end
                                r_state <= S_SQ;
                            end
                            default: ;
                        endcase
                    end
                end
                S_WAIT: begin
                    r_state <= r_ret;
                end
                S_PX: begin
                    r_ret   <= S_PY;
                    r_state <= S_WAIT;
                end
                S_PY: begin
                    r_est_x <= sat32(acc_q16 + 68'(r_est_x));
                    r_ret   <= S_PYD;
                    r_state <= S_WAIT;
                end
                S_PYD: begin
                    r_est_y <= sat32(acc_q16 + 68'(r_est_y));
                    r_cnt   <= '0;
                    r_state <= S_HAM;
                end
                S_HAM: begin
                    // previous component's sum is final in the accumulator here
                    if (ham_term == 2'd1 && ham_comp != 2'd0) begin
                        r_c[ham_comp - 2'd1] <= acc_q14[19:0];
                    end
                    if (ham_j == 4'd15) begin
                        r_ret   <= S_HAMD;
                        r_state <= S_WAIT;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_HAMD: begin
                    r_c[3]  <= acc_q14[19:0];
                    r_cnt   <= '0;
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    if (r_cnt[1:0] == 2'd3) begin
                        r_ret   <= S_SQD;
                        r_state <= S_WAIT;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_SQD: begin
                    if (mac_acc == '0) begin
                        for (int i = 0; i < 4; i++) begin
                            r_ori[i] <= '0;
                        end
                        r_state <= S_DONE;
                    end else begin
                        r_rem   <= {1'b0, mac_acc[38:0], 20'd0};
                        r_opb   <= 60'd1 << 58;
                        r_root  <= '0;
                        r_cnt   <= '0;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (cs_ge) begin
                        r_rem <= cs_diff;
                    end
                    r_root <= root_nx;
                    r_opb  <= r_opb >> 2;
                    if (r_cnt == 5'd29) begin
                        r_n     <= root_nx[29:0];
                        r_k     <= '0;
                        r_state <= S_DLD;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_DLD: begin
                    // rounded |c| * 2^24 / n
                    r_rem   <= {16'd0, c_abs, 24'd0} + {31'd0, r_n[29:1]};
                    r_opb   <= {16'd0, r_n, 14'd0};
                    r_root  <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (cs_ge) begin
                        r_rem <= cs_diff;
                    end
                    r_root <= {r_root[58:0], cs_ge};
                    r_opb  <= r_opb >> 1;
                    if (r_cnt == 5'd14) begin
                        r_ori[r_k] <= quo_s;
                        if (r_k == 2'd3) begin
                            r_state <= S_DONE;
                        end else begin
                            r_k     <= r_k + 2'd1;
                            r_state <= S_DLD;
                        end
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_KDIV: begin
                    r_rem  <= cs_ge ? cs_diff : cs_a;
                    r_root <= {r_root[58:0], cs_ge};
                    if (r_cnt == 5'd30) begin
                        r_state <= S_KX;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_KX: begin
                    r_ret   <= S_KY;
                    r_state <= S_WAIT;
                end
                S_KY: begin
                    r_est_x <= sat32(acc_q30 + 68'(r_est_x));
                    r_ret   <= S_VX;
                    r_state <= S_WAIT;
                end
                S_VX: begin
                    r_est_y <= sat32(acc_q30 + 68'(r_est_y));
                    r_ret   <= S_VY;
                    r_state <= S_WAIT;
                end
                S_VY: begin
                    r_var_x <= mac_acc[61:30];
                    r_ret   <= S_VD;
                    r_state <= S_WAIT;
                end
                S_VD: begin
                    r_var_y <= mac_acc[61:30];
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall = (r_state != S_IDLE) || r_out_valid;
    assign o_valid = r_out_valid;
    assign o_pos_x = r_est_x;
    assign o_pos_y = r_est_y;
    assign o_ori_w = r_ori[0];
    assign o_ori_x = r_ori[1];
    assign o_ori_y = r_ori[2];
    assign o_ori_z = r_ori[3];
    assign o_var_x = r_var_x;
    assign o_var_y = r_var_y;

    `PTGU_ASSERT_IMP(a_hold_while_pending, i_clk, i_rst_n, r_out_valid, o_stall, "word taken while result pending")
    `PTGU_ASSERT_NXT(a_busy_after_take, i_clk, i_rst_n, in_take, o_stall, "not busy after taking a word")
    `PTGU_ASSERT_IMP(a_sqrt_steps, i_clk, i_rst_n, r_state == S_SQRT, r_cnt < 5'd30, "square root overran")
    `PTGU_ASSERT_IMP(a_gain_range, i_clk, i_rst_n, r_state == S_KX, gain <= (31'd1 << 30), "gain above one")

endmodule
